// ===== hdl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants of the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned CNT_W  = 8;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_APPEND = 2'd2,
    REQ_DELETE = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic                     ins;    // insert accepted
    logic                     app;    // append accepted
    logic                     del;    // delete accepted
    logic [POS_W-1:0]         pos;
    logic [CNT_W-1:0]         cnt;    // count before the request
    logic signed [DATA_W-1:0] wdata;
  } cell_ctl_t;

endpackage

// ===== hdl/pal_if.sv =====
// ----------------------------------------------------------------------------
// pal_if
// Request and result channels: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface pal_req_if import pal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface pal_rsp_if import pal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] entry_out;
  logic [1:0]               status;
  logic [CNT_W-1:0]         count;
  logic                     empty_res;
  logic                     full_res;

  modport source (output valid, entry_out, status, count, empty_res, full_res,
                  input ready);
  modport sink   (input valid, entry_out, status, count, empty_res, full_res,
                  output ready);
endinterface

// ===== hdl/pal_cell.sv =====
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds an entry, shifts up or down with its neighbors.
// ----------------------------------------------------------------------------
module pal_cell import pal_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] left_in,   // entry of slot IDX-1
  input  logic signed [DATA_W-1:0] right_in,  // entry of slot IDX+1
  output logic signed [DATA_W-1:0] data_out,
  output logic signed [DATA_W-1:0] rd_out     // own entry when selected, else 0
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (MY_IDX > ctl.pos) begin
        data_nxt = left_in;
      end else if (MY_IDX == ctl.pos) begin
        data_nxt = ctl.wdata;
      end
    end else if (ctl.app) begin
      if (MY_IDX == ctl.cnt) begin
        data_nxt = ctl.wdata;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= ctl.pos) begin
        data_nxt = right_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;
  assign rd_out   = (MY_IDX == ctl.pos) ? data_r : '0;

endmodule

// ===== hdl/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list
// Bounded ordered list of signed 32-bit entries with read, insert, append
// and delete at a position, built as a row of shifting slot cells.
// ----------------------------------------------------------------------------
//
//   channel   dir   modport  payload
//   in_req    in    sink     req_type, position, value
//   out_rsp   out   source   entry_out, status, count, empty_res, full_res
//
// Cycles: one transaction per clock while out_rsp is not stalled. Every slot
//   cell updates in parallel each cycle, so an insert or delete shift completes
//   in the accept cycle; the result is registered and shows in the next cycle.
// Reset: rst_n (synchronous) clears the count and the result valid; the
//   slot contents are not reset, only slots below the count are ever read.
// Stalls: in_req.ready is high while the result register is empty or being
//   drained, so a stalled consumer holds off new requests by one slot.
//
module positional_array_list import pal_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  pal_req_if.sink   in_req,
  pal_rsp_if.source out_rsp
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic acc;

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign acc          = in_req.valid && in_req.ready;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     is_full;
  logic                     pos_lt_cnt;
  logic                     pos_le_cnt;
  status_t                  status_c;
  logic                     take_entry;   // read or delete that succeeds
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] rd_bus;

  assign is_full    = (count_r >= CAP_CNT);
  assign pos_lt_cnt = (in_req.position < count_r);
  assign pos_le_cnt = (in_req.position <= count_r);

  always_comb begin
    status_c   = ST_OK;
    take_entry = 1'b0;
    ctl        = '0;
    ctl.pos    = in_req.position;
    ctl.cnt    = count_r;
    ctl.wdata  = in_req.value;
    count_nxt  = count_r;
    case (req_kind_t'(in_req.req_type))
      REQ_READ: begin
        if (pos_lt_cnt) begin
          take_entry = 1'b1;
        end else begin
          status_c = ST_BADPOS;
        end
      end
      REQ_INSERT: begin
        // full check wins over the position check
        if (is_full) begin
          status_c = ST_FULL;
        end else if (!pos_le_cnt) begin
          status_c = ST_BADPOS;
        end else begin
          ctl.ins   = acc;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_APPEND: begin
        if (is_full) begin
          status_c = ST_FULL;
        end else begin
          ctl.app   = acc;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if (pos_lt_cnt) begin
          take_entry = 1'b1;
          ctl.del    = acc;
          count_nxt  = count_r - CNT_W'(1);
        end else begin
          status_c = ST_BADPOS;
        end
      end
      default: begin
        status_c = ST_BADPOS;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Slot cells: slot i holds list position i
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] cell_q  [CAPACITY];
  logic signed [DATA_W-1:0] cell_rd [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;  // slot 0 never takes from the left
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[i];  // top slot is past the count after a delete
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    pal_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .left_in  (left_d),
      .right_in (right_d),
      .data_out (cell_q[i]),
      .rd_out   (cell_rd[i])
    );
  end

  // One-hot select: only the slot at the requested position drives nonzero.
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end

  // --------------------------------------------------------------------------
  // Count and result register
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] entry_r;
  logic [1:0]               status_r;
  logic [CNT_W-1:0]         rcount_r;
  logic                     empty_r;
  logic                     full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      entry_r  <= take_entry ? rd_bus : '0;
      status_r <= status_c;
      rcount_r <= count_nxt;
      empty_r  <= (count_nxt == '0);
      full_r   <= (count_nxt == CAP_CNT);
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.entry_out = entry_r;
  assign out_rsp.status    = status_r;
  assign out_rsp.count     = rcount_r;
  assign out_rsp.empty_res = empty_r;
  assign out_rsp.full_res  = full_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(count_r))
    else $error("entry count moved without a transaction");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (out_rsp.count == count_r) && out_rsp.valid)
    else $error("reported count differs from list count");

  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.ins || ctl.app) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert or append did not grow the list");
`endif

endmodule

// ===== dv/positional_array_list_tb.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_tb
// Self-checking bench for the positional array list. A mirror list inside
// the scoreboard predicts every result. Directed requests come first, then
// random phases that grow the list to full, drain it to empty and churn it.
// ----------------------------------------------------------------------------
module positional_array_list_tb;
  import pal_pkg::*;

  localparam int unsigned LIST_CAP     = 128;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned MAX_WAIT     = 17;
  localparam int unsigned SHOWN_ERRORS = 10;

  // One result transaction as the block should present it.
  typedef struct packed {
    logic signed [DATA_W-1:0] entry;
    status_t                  status;
    logic [CNT_W-1:0]         count;
    logic                     empty;
    logic                     full;
  } list_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps a mirror of the list, turns each accepted request into
  // the result it must produce, and matches results in order.
  // --------------------------------------------------------------------------
  class list_scoreboard;
    logic signed [DATA_W-1:0] slots[LIST_CAP];
    int unsigned              fill;
    list_result_t             pending[$];
    int unsigned              mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted request to the mirror and queue its result.
    function void note_request(req_kind_t kind, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      list_result_t res;
      int unsigned  p;
      res.entry  = '0;
      res.status = ST_OK;
      p          = 32'(pos);
      case (kind)
        REQ_READ: begin
          if (p >= fill) res.status = ST_BADPOS;
          else res.entry = slots[p];
        end
        REQ_INSERT: begin
          // full is checked before the position
          if (fill >= LIST_CAP) res.status = ST_FULL;
          else if (p > fill) res.status = ST_BADPOS;
          else begin
            for (int i = fill; i > p; i--) slots[i] = slots[i-1];
            slots[p] = val;
            fill++;
          end
        end
        REQ_APPEND: begin
          if (fill >= LIST_CAP) res.status = ST_FULL;
          else begin
            slots[fill] = val;
            fill++;
          end
        end
        REQ_DELETE: begin
          if (p >= fill) res.status = ST_BADPOS;
          else begin
            res.entry = slots[p];
            for (int i = p; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
      endcase
      res.count = fill[CNT_W-1:0];
      res.empty = (fill == 0);
      res.full  = (fill == LIST_CAP);
      pending.push_back(res);
    endfunction

    function void flag(string what, list_result_t want, list_result_t got);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
        $display({"%0t %s: exp entry=%0d st=%0d cnt=%0d e=%0b f=%0b",
                  " | got entry=%0d st=%0d cnt=%0d e=%0b f=%0b"},
                 $realtime, what, want.entry, want.status, want.count, want.empty,
                 want.full, got.entry, got.status, got.count, got.empty, got.full);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(list_result_t got);
      list_result_t want;
      if (pending.size() == 0) begin
        want = '0;
        flag("unexpected result", want, got);
      end else begin
        want = pending.pop_front();
        if (got !== want) flag("result mismatch", want, got);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  pal_req_if req_ch ();
  pal_rsp_if rsp_ch ();

  positional_array_list #(.CAPACITY(LIST_CAP)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  list_scoreboard sb = new();

  // Quiet stretches: while a counter is nonzero that side does not idle.
  int unsigned req_calm = 0;
  int unsigned rsp_calm = 0;

  function automatic int unsigned draw_wait(ref int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(15, 70);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Drive one request and hold it until the block takes it. valid stays high
  // across back-to-back requests, so it is only lowered ahead of a gap.
  task automatic send_request(req_kind_t kind, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
    int unsigned gap;
    gap = draw_wait(req_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.position <= pos;
    req_ch.value    <= val;
    do @(posedge clk); while (!req_ch.ready);
    // accepted at this edge: predict now so the generator sees the new count
    sb.note_request(kind, pos, val);
  endtask

  // Random request shaped by the phase mix: add_pct percent grow the list,
  // del_pct percent shrink it, the rest read. A few are pure noise.
  task automatic random_request(int unsigned add_pct, int unsigned del_pct);
    req_kind_t        kind;
    logic [POS_W-1:0] pos;
    int unsigned      roll;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) kind = ($urandom_range(0, 1) != 0) ? REQ_INSERT : REQ_APPEND;
    else if (roll < add_pct + del_pct) kind = REQ_DELETE;
    else kind = REQ_READ;
    if ($urandom_range(0, 99) < 8) begin
      // noise: any kind, any position, mostly out of range
      kind = req_kind_t'($urandom_range(0, 3));
      pos  = POS_W'($urandom_range(0, 255));
    end else if (kind == REQ_INSERT) begin
      pos = POS_W'($urandom_range(0, sb.fill));
    end else if (sb.fill > 0) begin
      pos = POS_W'($urandom_range(0, sb.fill - 1));
    end else begin
      pos = '0;
    end
    send_request(kind, pos, $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, one check per accepted transaction
  // --------------------------------------------------------------------------
  initial begin
    list_result_t got;
    int unsigned  stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = draw_wait(rsp_calm);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      got.entry  = rsp_ch.entry_out;
      got.status = status_t'(rsp_ch.status);
      got.count  = rsp_ch.count;
      got.empty  = rsp_ch.empty_res;
      got.full   = rsp_ch.full_res;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned span;
    int unsigned phase;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_READ;
    req_ch.position <= '0;
    req_ch.value    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list errors, value extremes, insert at the end,
    // insert past the end, read at the count, deletes at head/middle/tail.
    send_request(REQ_READ,   8'd0,   32'sd0);
    send_request(REQ_DELETE, 8'd0,   32'sd0);
    send_request(REQ_READ,   8'd255, 32'sd0);
    send_request(REQ_APPEND, 8'd255, 32'h7fff_ffff);
    send_request(REQ_APPEND, 8'd0,   32'h8000_0000);
    send_request(REQ_INSERT, 8'd0,   -32'sd1);
    send_request(REQ_INSERT, 8'd3,   32'sd0);          // at count: acts as append
    send_request(REQ_INSERT, 8'd5,   32'sd7);          // past count
    send_request(REQ_INSERT, 8'd255, 32'sd9);
    send_request(REQ_READ,   8'd0,   32'hffff_ffff);
    send_request(REQ_READ,   8'd3,   32'sd0);
    send_request(REQ_READ,   8'd4,   32'sd0);          // at count
    send_request(REQ_DELETE, 8'd1,   32'sd0);
    send_request(REQ_DELETE, 8'd255, 32'sd0);
    send_request(REQ_DELETE, 8'd2,   32'sd0);          // last entry
    send_request(REQ_READ,   8'd1,   32'sd0);
    send_request(REQ_APPEND, 8'd128, 32'h5555_5555);
    send_request(REQ_INSERT, 8'd1,   32'haaaa_aaaa);
    send_request(REQ_DELETE, 8'd0,   32'sd0);
    send_request(REQ_READ,   8'd2,   32'sd0);
    send_request(REQ_DELETE, 8'd0,   32'sd0);
    send_request(REQ_DELETE, 8'd0,   32'sd0);
    send_request(REQ_DELETE, 8'd0,   32'sd0);          // back to empty
    send_request(REQ_DELETE, 8'd0,   32'sd0);

    // Random phases. Grow phases can be long enough to hit full, where inserts
    // at any position and appends must report full; shrink phases drain it.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase = $urandom_range(0, 2);
      span  = $urandom_range(60, 260);
      for (int unsigned n = 0; n < span && sent < RANDOM_ITEMS; n++) begin
        case (phase)
          0:       random_request(75, 12);
          1:       random_request(15, 70);
          default: random_request(40, 40);
        endcase
        sent++;
      end
    end

    // last request was taken at this edge: drop valid before the next one
    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
